// ===== hw/rtl/tcgr_pkg.sv =====
// Shared types and constants for the text console glyph renderer.
// Depends on nothing; imported by tcgr_ram users and the top level.
package tcgr_pkg;

   localparam int GLYPH_COUNT  = 512;
   localparam int ROW_LIMIT    = 32;
   localparam int NARROW_COUNT = 256;
   localparam int GLYPH_AW     = $clog2(GLYPH_COUNT);
   localparam int ROW_W        = $clog2(ROW_LIMIT);
   localparam int FONT_DEPTH   = GLYPH_COUNT * ROW_LIMIT;

   localparam int CODE_W   = 9;
   localparam int CH_W     = 6;
   localparam int COORD_W  = 16;
   localparam int MASK_W   = 8;
   localparam int COLOR_W  = 24;
   localparam int CSR_IX_W = 2;
   localparam int CSR_DW   = 24;

   localparam logic [CODE_W-1:0]  CODE_TAB      = 9'd9;
   localparam logic [CODE_W-1:0]  CODE_NEWLINE  = 9'd10;
   localparam logic [COORD_W-1:0] GLYPH_ADVANCE = 16'd8;
   localparam logic [COORD_W-1:0] TAB_ADVANCE   = 16'd32;

   localparam logic [CH_W-1:0]    RST_CHAR_HEIGHT  = 6'd16;
   localparam logic [COORD_W-1:0] RST_SCREEN_WIDTH = 16'd1024;
   localparam logic [COLOR_W-1:0] RST_TEXT_COLOR   = 24'h55FFFF;

   typedef enum logic [CSR_IX_W-1:0] {
      CSR_CHAR_HEIGHT = 2'd0,
      CSR_WIDE_FONT   = 2'd1,
      CSR_SCREEN_W    = 2'd2,
      CSR_TEXT_COLOR  = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_FONT_WRITE = 1'b0,
      CMD_PUT        = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

endpackage

// ===== hw/rtl/tcgr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued. No dependencies.
module tcgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/text_console_glyph_renderer.sv =====
// Text console glyph renderer: cursor, font memory and row emitter.
// Depends on tcgr_pkg and tcgr_ram.
// Font write, newline, tab, invalid glyph: done on acceptance, block stays idle.
// Drawn glyph: reads min(char_height, 32) rows; one font memory read per cycle
//   unless results stall; each row passes the RAM read and output registers.
// Reset: synchronous, active high; clears cursor and control, presets config regs.
//   Font memory is not cleared and holds no data until written.
module text_console_glyph_renderer (
   input  logic                            clock,
   input  logic                            reset,
   // configuration writes
   input  logic                            csr_wr_en,
   input  logic [tcgr_pkg::CSR_IX_W-1:0]   csr_index,
   input  logic [tcgr_pkg::CSR_DW-1:0]     csr_wdata,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_command,
   input  logic [tcgr_pkg::CODE_W-1:0]     req_char_code,
   input  logic [4:0]                      req_glyph_row,
   input  logic [tcgr_pkg::MASK_W-1:0]     req_row_bits,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tcgr_pkg::COORD_W-1:0]    rsp_pixel_x,
   output logic [tcgr_pkg::COORD_W-1:0]    rsp_pixel_y,
   output logic [tcgr_pkg::MASK_W-1:0]     rsp_pixel_mask,
   output logic [tcgr_pkg::COLOR_W-1:0]    rsp_pixel_color,
   output logic                            rsp_last_row
);
   import tcgr_pkg::*;

   // ---------------- configuration registers ----------------
   logic [CH_W-1:0]    char_height_ff;
   logic               wide_font_ff;
   logic [COORD_W-1:0] screen_width_ff;
   logic [COLOR_W-1:0] text_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         char_height_ff  <= RST_CHAR_HEIGHT;
         wide_font_ff    <= 1'b0;
         screen_width_ff <= RST_SCREEN_WIDTH;
         text_color_ff   <= RST_TEXT_COLOR;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_CHAR_HEIGHT: char_height_ff  <= csr_wdata[CH_W-1:0];
            CSR_WIDE_FONT:   wide_font_ff    <= csr_wdata[0];
            CSR_SCREEN_W:    screen_width_ff <= csr_wdata[COORD_W-1:0];
            CSR_TEXT_COLOR:  text_color_ff   <= csr_wdata[COLOR_W-1:0];
            default:         ;
         endcase
      end
   end

   // ---------------- control state ----------------
   state_type          state_ff, state_in;
   logic [COORD_W-1:0] cur_col_ff, cur_col_in;
   logic [COORD_W-1:0] cur_row_ff, cur_row_in;

   // per-glyph draw context, loaded on acceptance of a drawn glyph
   logic [GLYPH_AW-1:0] code_ff, code_in;
   logic [ROW_W-1:0]    rix_ff, rix_in;      // next glyph row to read
   logic [ROW_W-1:0]    last_ix_ff, last_ix_in;
   logic [COORD_W-1:0]  x_ff, x_in;
   logic [COORD_W-1:0]  y_ff, y_in;

   // read stage: metadata for the row now sitting in the RAM read register
   logic                rd_vld_ff, rd_vld_in;
   logic [COORD_W-1:0]  rd_x_ff, rd_x_in;
   logic [COORD_W-1:0]  rd_y_ff, rd_y_in;
   logic                rd_last_ff, rd_last_in;

   // output register
   logic                out_vld_ff, out_vld_in;
   logic [COORD_W-1:0]  out_x_ff;
   logic [COORD_W-1:0]  out_y_ff;
   logic [MASK_W-1:0]   out_mask_ff;
   logic [COLOR_W-1:0]  out_color_ff;
   logic                out_last_ff;

   // ---------------- request decode ----------------
   logic                req_fire;
   logic                is_put;
   logic                is_newline;
   logic                is_tab;
   logic                wrap;
   logic [COORD_W-1:0]  line_down;
   logic [COORD_W-1:0]  base_col;
   logic [COORD_W-1:0]  base_row;
   logic                glyph_ok;
   logic [CH_W-1:0]     row_count;
   logic                draw;
   logic                font_wr;

   // font memory traffic
   logic                     rd_issue;
   logic                     out_load;
   logic [MASK_W-1:0]        rd_data;
   logic [GLYPH_AW+ROW_W-1:0] wr_addr;
   logic [GLYPH_AW+ROW_W-1:0] rd_addr;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;

   always_comb begin
      is_put     = (command_type'(req_command) == CMD_PUT);
      is_newline = (req_char_code == CODE_NEWLINE);
      is_tab     = (req_char_code == CODE_TAB);
      line_down  = cur_row_ff + {{(COORD_W-CH_W){1'b0}}, char_height_ff};
      // wrap happens when the cursor sits strictly past the screen width
      wrap       = (cur_col_ff > screen_width_ff);
      base_col   = wrap ? '0 : cur_col_ff;
      base_row   = wrap ? line_down : cur_row_ff;
      glyph_ok   = (32'(req_char_code) < GLYPH_COUNT)
                   && (wide_font_ff || (32'(req_char_code) < NARROW_COUNT));
      row_count  = (32'(char_height_ff) > ROW_LIMIT) ? CH_W'(ROW_LIMIT)
                                                     : char_height_ff;
      draw       = is_put && !is_newline && !is_tab && glyph_ok
                   && (row_count != '0);
      font_wr    = req_fire && !is_put
                   && (32'(req_char_code) < GLYPH_COUNT)
                   && (32'(req_glyph_row) < ROW_LIMIT);
   end

   // ---------------- row pipeline handshake ----------------
   // A new read overwrites the RAM read register, so it is issued only when
   // that register is empty or is moving into the output register now.
   assign out_load = rd_vld_ff && (!out_vld_ff || rsp_ready);
   assign rd_issue = (state_ff == ST_RUN) && (!rd_vld_ff || out_load);

   assign wr_addr = {req_char_code[GLYPH_AW-1:0], req_glyph_row[ROW_W-1:0]};
   assign rd_addr = {code_ff, rix_ff};

   tcgr_ram #(
      .WIDTH (MASK_W),
      .DEPTH (FONT_DEPTH)
   ) u_font_ram (
      .clock   (clock),
      .wr_en   (font_wr),
      .wr_addr (wr_addr),
      .wr_data (req_row_bits),
      .rd_en   (rd_issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------- next state ----------------
   always_comb begin
      state_in   = state_ff;
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      code_in    = code_ff;
      rix_in     = rix_ff;
      last_ix_in = last_ix_ff;
      x_in       = x_ff;
      y_in       = y_ff;

      rd_vld_in  = rd_vld_ff;
      rd_x_in    = rd_x_ff;
      rd_y_in    = rd_y_ff;
      rd_last_in = rd_last_ff;

      out_vld_in = out_vld_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_put) begin
               priority if (is_newline) begin
                  cur_col_in = '0;
                  cur_row_in = line_down;
               end else if (is_tab) begin
                  cur_col_in = cur_col_ff + TAB_ADVANCE;
               end else begin
                  // column advances whether or not a glyph is drawn
                  cur_col_in = base_col + GLYPH_ADVANCE;
                  cur_row_in = base_row;
                  if (draw) begin
                     state_in   = ST_RUN;
                     code_in    = req_char_code[GLYPH_AW-1:0];
                     rix_in     = '0;
                     last_ix_in = ROW_W'(row_count - 1'b1);
                     x_in       = base_col;
                     y_in       = base_row;
                  end
               end
            end
         end
         ST_RUN: begin
            if (rd_issue) begin
               rix_in = rix_ff + 1'b1;
               if (rix_ff == last_ix_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // read stage
      if (rd_issue) begin
         rd_vld_in  = 1'b1;
         rd_x_in    = x_ff;
         rd_y_in    = y_ff + {{(COORD_W-ROW_W){1'b0}}, rix_ff};
         rd_last_in = (rix_ff == last_ix_ff);
      end else if (out_load) begin
         rd_vld_in  = 1'b0;
      end

      // output stage
      if (out_load) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cur_col_ff <= '0;
         cur_row_ff <= '0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      code_ff    <= code_in;
      rix_ff     <= rix_in;
      last_ix_ff <= last_ix_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      rd_x_ff    <= rd_x_in;
      rd_y_ff    <= rd_y_in;
      rd_last_ff <= rd_last_in;
      if (out_load) begin
         out_x_ff     <= rd_x_ff;
         out_y_ff     <= rd_y_ff;
         out_mask_ff  <= rd_data;
         out_color_ff <= text_color_ff;
         out_last_ff  <= rd_last_ff;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_pixel_x     = out_x_ff;
   assign rsp_pixel_y     = out_y_ff;
   assign rsp_pixel_mask  = out_mask_ff;
   assign rsp_pixel_color = out_color_ff;
   assign rsp_last_row    = out_last_ff;

   // ---------------- assertions ----------------
   // a pending row in the read register is never overwritten
   a_no_rd_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(rd_issue && rd_vld_ff && !out_load))
      else $error("font read issued over an unconsumed row");

   // a drawn glyph always starts the row sequencer
   a_draw_starts_run: assert property (@(posedge clock) disable iff (reset)
      (req_fire && draw) |=> (state_ff == ST_RUN))
      else $error("drawn glyph did not start row reads");

   // read stage only fills from an issued read or holds a stalled row
   a_rd_vld_source: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> ($past(rd_issue) || $past(rd_vld_ff && !out_load)))
      else $error("read stage valid without a source");

   // an output row appears only after the read stage held one
   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(rd_vld_ff))
      else $error("output row without a read");

endmodule

// ===== test/text_console_glyph_renderer_checker.sv =====
// Checker for the text console glyph renderer: watches the request, result and
// csr ports, predicts the glyph rows and compares them. Depends on tcgr_pkg.
`timescale 1ns / 100ps

module text_console_glyph_renderer_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [tcgr_pkg::CSR_IX_W-1:0] csr_index,
   input  logic [tcgr_pkg::CSR_DW-1:0]   csr_wdata,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_command,
   input  logic [tcgr_pkg::CODE_W-1:0]   req_char_code,
   input  logic [4:0]                    req_glyph_row,
   input  logic [tcgr_pkg::MASK_W-1:0]   req_row_bits,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [tcgr_pkg::COORD_W-1:0]  rsp_pixel_x,
   input  logic [tcgr_pkg::COORD_W-1:0]  rsp_pixel_y,
   input  logic [tcgr_pkg::MASK_W-1:0]   rsp_pixel_mask,
   input  logic [tcgr_pkg::COLOR_W-1:0]  rsp_pixel_color,
   input  logic                          rsp_last_row,
   output int                            mismatches,
   output int                            rows_pending
);
   import tcgr_pkg::*;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [MASK_W-1:0]  mask;
      logic [COLOR_W-1:0] color;
      logic               last;
   } glyph_row_type;

   glyph_row_type rows_due[$];

   logic [CH_W-1:0]    char_height;
   logic               wide_font;
   logic [COORD_W-1:0] screen_width;
   logic [COLOR_W-1:0] text_color;
   logic [COORD_W-1:0] cursor_col;
   logic [COORD_W-1:0] cursor_row;
   logic [MASK_W-1:0]  font_rows [FONT_DEPTH];

   task automatic line_feed();
      cursor_col = '0;
      cursor_row = cursor_row + char_height;
   endtask

   // Cursor and font update for one request; queues the rows it draws.
   task automatic render_request(input command_type cmd, input logic [CODE_W-1:0] code,
                                 input logic [4:0] grow, input logic [MASK_W-1:0] bits);
      int            n;
      int            r;
      glyph_row_type due;
      if (cmd == CMD_FONT_WRITE) begin
         // row limit of 32 makes the entry index a plain concatenation
         font_rows[{code, grow}] = bits;
      end else if (code == CODE_NEWLINE) begin
         line_feed();
      end else if (code == CODE_TAB) begin
         cursor_col = cursor_col + TAB_ADVANCE;
      end else begin
         if (cursor_col > screen_width)
            line_feed();
         if (code < (wide_font ? GLYPH_COUNT : NARROW_COUNT)) begin
            n = (char_height < ROW_LIMIT) ? int'(char_height) : ROW_LIMIT;
            for (r = 0; r < n; r++) begin
               due.x     = cursor_col;
               due.y     = cursor_row + COORD_W'(r);
               due.mask  = font_rows[{code, ROW_W'(r)}];
               due.color = text_color;
               due.last  = (r == n - 1);
               rows_due.push_back(due);
            end
         end
         cursor_col = cursor_col + GLYPH_ADVANCE;
      end
   endtask

   task automatic compare_row();
      glyph_row_type due;
      if (rows_due.size() == 0) begin
         $error("unexpected glyph row: x=%0d y=%0d mask=%02h",
                rsp_pixel_x, rsp_pixel_y, rsp_pixel_mask);
         mismatches++;
      end else begin
         due = rows_due.pop_front();
         if (rsp_pixel_x !== due.x) begin
            $error("pixel_x: expected %0d, got %0d", due.x, rsp_pixel_x);
            mismatches++;
         end
         if (rsp_pixel_y !== due.y) begin
            $error("pixel_y: expected %0d, got %0d", due.y, rsp_pixel_y);
            mismatches++;
         end
         if (rsp_pixel_mask !== due.mask) begin
            $error("pixel_mask: expected %02h, got %02h", due.mask, rsp_pixel_mask);
            mismatches++;
         end
         if (rsp_pixel_color !== due.color) begin
            $error("pixel_color: expected %06h, got %06h", due.color, rsp_pixel_color);
            mismatches++;
         end
         if (rsp_last_row !== due.last) begin
            $error("last_row: expected %0b, got %0b", due.last, rsp_last_row);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         char_height  = RST_CHAR_HEIGHT;
         wide_font    = 1'b0;
         screen_width = RST_SCREEN_WIDTH;
         text_color   = RST_TEXT_COLOR;
         cursor_col   = '0;
         cursor_row   = '0;
         mismatches   = 0;
         rows_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_CHAR_HEIGHT: char_height  = csr_wdata[CH_W-1:0];
               CSR_WIDE_FONT:   wide_font    = csr_wdata[0];
               CSR_SCREEN_W:    screen_width = csr_wdata[COORD_W-1:0];
               CSR_TEXT_COLOR:  text_color   = csr_wdata[COLOR_W-1:0];
               default: ;
            endcase
         end
         // results first: nothing accepted on this edge can show up on it
         if (rsp_valid && rsp_ready)
            compare_row();
         if (req_valid && req_ready)
            render_request(command_type'(req_command), req_char_code, req_glyph_row,
                           req_row_bits);
      end
      rows_pending <= rows_due.size();
   end

endmodule

// ===== test/text_console_glyph_renderer_test.sv =====
// Testbench top for the text console glyph renderer: drives requests, csr
// writes and result back-pressure. Depends on tcgr_pkg and the checker module.
`timescale 1ns / 100ps

module text_console_glyph_renderer_test;
   import tcgr_pkg::*;

   // safety net, far beyond the slowest run this stimulus can produce
   localparam longint TIMEOUT_NS = 20_000_000;
   localparam int     SETTLE_CYCLES = 40;   // covers the longest glyph plus pipeline
   localparam int     SINK_CHOKE_CYCLES = 400;
   localparam int     POOL_SIZE = 6;
   localparam int     BURST_LEN = 12;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [CSR_IX_W-1:0] csr_index = '0;
   logic [CSR_DW-1:0]   csr_wdata = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_command = 1'b0;
   logic [CODE_W-1:0]   req_char_code = '0;
   logic [4:0]          req_glyph_row = '0;
   logic [MASK_W-1:0]   req_row_bits = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [COORD_W-1:0]  rsp_pixel_x;
   logic [COORD_W-1:0]  rsp_pixel_y;
   logic [MASK_W-1:0]   rsp_pixel_mask;
   logic [COLOR_W-1:0]  rsp_pixel_color;
   logic                rsp_last_row;
   int                  mismatches;
   int                  rows_pending;

   // stimulus-side knowledge only: which font rows hold data, and the
   // height/mode needed to know which rows a put will read
   bit [ROW_LIMIT-1:0]  rows_loaded [GLYPH_COUNT];
   logic [CH_W-1:0]     cfg_height = RST_CHAR_HEIGHT;
   logic                cfg_wide = 1'b0;
   logic [CODE_W-1:0]   glyph_pool [POOL_SIZE];
   bit                  quiet = 1'b0;       // no idling on either side
   int                  rsp_hold_cycles = 0;

   text_console_glyph_renderer u_dut (.*);

   text_console_glyph_renderer_checker u_checker (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mostly no gap, some short ones, a few long ones.
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(99);
      if (quiet || pick < 60)
         return 0;
      else if (pick < 90)
         return $urandom_range(3, 1);
      else if (pick < 98)
         return $urandom_range(12, 4);
      else
         return $urandom_range(60, 20);
   endfunction

   // Font row contents, leaning on the all-clear and all-set rows.
   function automatic logic [MASK_W-1:0] row_pattern();
      case ($urandom_range(5))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return MASK_W'($urandom);
      endcase
   endfunction

   // Called and returns on a falling edge. Valid stays up between back-to-back
   // requests; it only drops when a gap is taken.
   task automatic send_request(input command_type cmd, input logic [CODE_W-1:0] code,
                               input logic [4:0] grow, input logic [MASK_W-1:0] bits);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_char_code <= code;
      req_glyph_row <= grow;
      req_row_bits  <= bits;
      if (cmd == CMD_FONT_WRITE)
         rows_loaded[code][grow] = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Put a character. A drawable glyph first gets any row it will read that
   // was never loaded, so the font is never read before it is written.
   task automatic put_char(input logic [CODE_W-1:0] code);
      int needed;
      int r;
      needed = (cfg_height < ROW_LIMIT) ? int'(cfg_height) : ROW_LIMIT;
      if (code != CODE_NEWLINE && code != CODE_TAB &&
          code < (cfg_wide ? GLYPH_COUNT : NARROW_COUNT)) begin
         for (r = 0; r < needed; r++)
            if (!rows_loaded[code][r])
               send_request(CMD_FONT_WRITE, code, ROW_W'(r), row_pattern());
      end
      // glyph_row and row_bits are don't-care on a put; toggle them anyway
      send_request(CMD_PUT, code, 5'($urandom), MASK_W'($urandom));
   endtask

   // Stop offering, wait for every predicted row, then let the block go idle.
   task automatic settle();
      req_valid <= 1'b0;
      while (rows_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type ix, input logic [CSR_DW-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= ix;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_height(input logic [CH_W-1:0] height);
      settle();
      write_reg(CSR_CHAR_HEIGHT, CSR_DW'(height));
      cfg_height = height;
   endtask

   task automatic set_config(input logic [CH_W-1:0] height, input logic wide,
                             input logic [COORD_W-1:0] width,
                             input logic [COLOR_W-1:0] color);
      set_height(height);
      write_reg(CSR_WIDE_FONT, CSR_DW'(wide));
      write_reg(CSR_SCREEN_W, CSR_DW'(width));
      write_reg(CSR_TEXT_COLOR, CSR_DW'(color));
      cfg_wide = wide;
   endtask

   // Random traffic: mostly glyphs from a small pool (so the font stays
   // loaded), with tabs, newlines, out-of-range glyphs and stray font writes.
   task automatic random_stream(input int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 52)
            put_char(glyph_pool[$urandom_range(POOL_SIZE - 1)]);
         else if (pick < 57)
            put_char(CODE_W'($urandom_range(GLYPH_COUNT - 1)));
         else if (pick < 65)
            put_char(CODE_TAB);
         else if (pick < 72)
            put_char(CODE_NEWLINE);
         else if (pick < 80)
            put_char(CODE_W'($urandom_range(GLYPH_COUNT - 1, NARROW_COUNT)));
         else if (pick < 92)
            send_request(CMD_FONT_WRITE, glyph_pool[$urandom_range(POOL_SIZE - 1)],
                         5'($urandom), row_pattern());
         else
            send_request(CMD_FONT_WRITE, CODE_W'($urandom), 5'($urandom), row_pattern());
      end
   endtask

   task automatic run_phase(input logic [CH_W-1:0] height, input logic wide,
                            input logic [COORD_W-1:0] width,
                            input logic [COLOR_W-1:0] color,
                            input bit calm, input bit choke_sink, input bit drain_midway);
      set_config(height, wide, width, color);
      quiet = calm;
      // sink goes dark while requests keep coming: the block backs up
      if (choke_sink)
         rsp_hold_cycles = SINK_CHOKE_CYCLES;
      random_stream(BURST_LEN);
      // sender holds until every outstanding row is back
      if (drain_midway)
         settle();
      random_stream(BURST_LEN);
      quiet = 1'b0;
   endtask

   // Result side: random stalls, plus one long choke on request.
   initial begin : result_sink
      int stall;
      int hold_left;
      stall     = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            hold_left       = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left = hold_left - 1;
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall = stall - 1;
         end else begin
            rsp_ready <= 1'b1;
            stall = idle_length();
         end
      end
   end

   initial begin : stimulus
      int r;
      glyph_pool[0] = '0;
      glyph_pool[1] = CODE_W'(NARROW_COUNT - 1);
      glyph_pool[2] = CODE_W'(NARROW_COUNT);
      glyph_pool[3] = CODE_W'(GLYPH_COUNT - 1);
      glyph_pool[4] = 9'd65;
      for (r = 5; r < POOL_SIZE; r++)
         glyph_pool[r] = CODE_W'($urandom_range(GLYPH_COUNT - 1));

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, at reset settings (height 16, narrow font, width 1024).
      // Glyph 'A' gets the extreme row patterns, the rest fill randomly.
      send_request(CMD_FONT_WRITE, 9'd65, 5'd0, 8'h00);
      send_request(CMD_FONT_WRITE, 9'd65, 5'd1, 8'hFF);
      send_request(CMD_FONT_WRITE, 9'd65, 5'd2, 8'h80);
      send_request(CMD_FONT_WRITE, 9'd65, 5'd3, 8'h01);
      send_request(CMD_FONT_WRITE, 9'd65, 5'd4, 8'hAA);
      send_request(CMD_FONT_WRITE, 9'd65, 5'd5, 8'h55);
      put_char(9'd65);                    // x 0, y 0..15
      put_char(CODE_TAB);                 // column 40
      put_char(CODE_W'(NARROW_COUNT));    // not drawable in narrow mode, column 48
      put_char(CODE_W'(GLYPH_COUNT - 1)); // same, column 56
      put_char(9'd65);                    // x 56
      put_char(CODE_NEWLINE);             // row 16
      put_char(9'd65);
      put_char(CODE_NEWLINE);             // row 32, column 0

      // Wide font, height beyond the row limit.
      set_config(6'd63, 1'b1, 16'hFFFF, 24'hFFFFFF);
      quiet = 1'b1;
      put_char(CODE_W'(GLYPH_COUNT - 1)); // 32 rows at x 0, y 32..63
      set_height(6'd31);
      put_char(CODE_NEWLINE);             // row 63, column 0
      set_height(6'd40);
      put_char(CODE_W'(GLYPH_COUNT - 1)); // 32 rows, y 63..94
      quiet = 1'b0;

      // Random phases over a spread of settings, extremes included.
      run_phase(6'd8,  1'b0, 16'd200, 24'($urandom), 1'b0, 1'b0, 1'b1);
      run_phase(6'd32, 1'b0, 16'($urandom), 24'($urandom), 1'b0, 1'b1, 1'b0);
      run_phase(6'd0,  1'b1, 16'd100, 24'($urandom), 1'b0, 1'b0, 1'b0);  // nothing drawn
      run_phase(6'd1,  1'b0, 16'd0, 24'h000000, 1'b1, 1'b0, 1'b0);  // wraps on every glyph not at column 0
      run_phase(6'd33, 1'b0, 16'($urandom), 24'hFFFFFF, 1'b0, 1'b0, 1'b0);
      run_phase(6'd5,  1'b1, 16'd64, 24'($urandom), 1'b0, 1'b0, 1'b1);
      run_phase(6'd63, 1'b0, 16'd512, 24'($urandom), 1'b0, 1'b0, 1'b0);

      settle();
      if (mismatches == 0)
         $display("text_console_glyph_renderer_test: done, clean");
      else
         $display("text_console_glyph_renderer_test: done, errors");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("text_console_glyph_renderer_test: done, errors");
      $finish;
   end

endmodule
